// ===== sv/pstb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstb_pkg
// Shared types and constants for the periodic soft timer bank.
// ----------------------------------------------------------------------------
package pstb_pkg;

	typedef logic [1:0] action_t;

	localparam action_t ACT_TICK  = 2'd0;
	localparam action_t ACT_START = 2'd1;
	localparam action_t ACT_CHECK = 2'd2;

	localparam int STAMP_W    = 32;
	localparam int TPU_W      = 8;
	localparam int BASE_W     = 26;              // ms*1000 + us fits in 26 bits
	localparam int REQ_W      = BASE_W + TPU_W;  // required tick count
	localparam logic [TPU_W-1:0] TPU_RESET = 8'd75;
	localparam logic [BASE_W-1:0] US_PER_MS = 26'd1000;

	typedef struct packed {
		action_t     action;
		logic [7:0]  timer_id;
		logic [15:0] interval_ms;
		logic [15:0] interval_us;
	} in_item_t;

	typedef struct packed {
		logic expired;
		logic id_out_of_range;
	} out_item_t;

	// Decision of the evaluate stage, applied to the state at the end of the item.
	typedef struct packed {
		logic expired;
		logic bad_id;
		logic stamp_we;
		logic set_valid;
		logic tick;
	} decision_t;

endpackage

// ===== sv/periodic_soft_timer_bank_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_soft_timer_bank_core
// Bank of periodic software timers sharing one 32-bit tick counter that tick items advance.
// ----------------------------------------------------------------------------
// Each input beat is a tick, a timer start, a timer check or the unused code
// (which changes nothing), and produces exactly one result beat. In the
// accept cycle the timer's start stamp is read from a synchronous RAM and
// ms*1000+us is registered; in the evaluate stage the interval is scaled by
// ticks_per_us, the elapsed count is compared and the stamp is written back.
// Items can follow back to back at one per cycle while the output does not
// stall: a new item is accepted in the cycle its predecessor completes, so
// its stamp read overlaps that write-back, and a read of the stamp just being
// written is forwarded. Output backpressure stalls the evaluate stage until
// the result register frees up. The stamp RAM is not cleared: valid bits in
// flops, cleared at reset, guard every stamp read, so the block is ready
// right after reset. Write ticks_per_us only while idle.
// ----------------------------------------------------------------------------
module periodic_soft_timer_bank_core
	import pstb_pkg::*;
#(
	parameter int NUM_TIMERS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [TPU_W-1:0] cfg_wdata
);

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	// Control and state
	logic                  busy_q;
	logic                  out_valid_q;
	out_item_t             out_data_q;
	logic [TPU_W-1:0]      tpu_q;
	logic [STAMP_W-1:0]    tick_q;
	logic [NUM_TIMERS-1:0] valid_q;

	// Evaluate-stage registers
	action_t               action_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  in_range_s1;
	logic [BASE_W-1:0]     base_s1;
	logic                  fwd_s1;
	logic [STAMP_W-1:0]    fwd_data_s1;

	logic                  accept;
	logic                  done;
	logic                  in_range;
	logic [IDX_W-1:0]      in_idx;
	logic [STAMP_W-1:0]    ram_rdata;
	logic [STAMP_W-1:0]    stamp;
	logic                  valid_bit;
	logic                  ram_we;
	decision_t             dec;

	// Finish the item once the result register is free; take the next one then.
	assign done     = busy_q && (!out_valid_q || out_ready);
	assign in_ready = !busy_q || done;
	assign accept   = in_valid && in_ready;

	assign in_range = {1'b0, in_data.timer_id} < 9'(NUM_TIMERS);
	assign in_idx   = in_data.timer_id[IDX_W-1:0];

	assign ram_we = done && dec.stamp_we;

	pstb_ram #(
		.WIDTH (STAMP_W),
		.DEPTH (NUM_TIMERS),
		.AW    (IDX_W)
	) u_stamp_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1),
		.wdata (tick_q),
		.re    (accept),
		.raddr (in_idx),
		.rdata (ram_rdata)
	);

	// Use the forwarded stamp when the read met a write to the same timer.
	assign stamp     = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign valid_bit = in_range_s1 ? valid_q[idx_s1] : 1'b0;

	pstb_eval u_eval (
		.action       (action_s1),
		.in_range     (in_range_s1),
		.timer_valid  (valid_bit),
		.base         (base_s1),
		.ticks_per_us (tpu_q),
		.counter      (tick_q),
		.stamp        (stamp),
		.dec          (dec)
	);

	// Capture the item: hold fields and the interval sum for the evaluate cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1   <= in_data.action;
			idx_s1      <= in_idx;
			in_range_s1 <= in_range;
			base_s1     <= BASE_W'(in_data.interval_ms) * US_PER_MS
				+ BASE_W'(in_data.interval_us);
			fwd_s1      <= ram_we && (idx_s1 == in_idx);
			fwd_data_s1 <= tick_q;
		end
	end

	// Result register: load on completion, drop once taken.
	always_ff @(posedge clk) begin
		if (done) begin
			out_data_q.expired         <= dec.expired;
			out_data_q.id_out_of_range <= dec.bad_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			tpu_q       <= TPU_RESET;
			tick_q      <= '0;
			valid_q     <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end

			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				tpu_q <= cfg_wdata;
			end

			// Advance the counter on a tick.
			if (done && dec.tick) begin
				tick_q <= tick_q + 32'd1;
			end

			if (done && dec.set_valid) begin
				valid_q[idx_s1] <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Every completed item leaves a result in the output register.
	a_done_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> out_valid_q)
		else $error("completed item did not present a result");

	// Stamps are written only for timers inside the bank.
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> in_range_s1)
		else $error("stamp write for an out-of-range timer");

	// The counter moves only when a tick item completes.
	a_counter_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(done && action_s1 == ACT_TICK) |=> $stable(tick_q))
		else $error("tick counter changed without a tick");

	// A stalled evaluate stage keeps its item.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !done |=> busy_q && $stable(action_s1) && $stable(idx_s1))
		else $error("stalled item lost");

endmodule

// ===== sv/pstb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstb_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pstb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read-first: a read at the written address returns the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/pstb_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstb_eval
// Evaluate stage: deadline multiply, elapsed time and the per-action decision.
// ----------------------------------------------------------------------------
module pstb_eval
	import pstb_pkg::*;
(
	input  action_t             action,
	input  logic                in_range,
	input  logic                timer_valid,
	input  logic [BASE_W-1:0]   base,
	input  logic [TPU_W-1:0]    ticks_per_us,
	input  logic [STAMP_W-1:0]  counter,
	input  logic [STAMP_W-1:0]  stamp,
	output decision_t           dec
);

	logic [REQ_W-1:0]   required;
	logic [STAMP_W-1:0] elapsed;
	logic               reached;

	assign required = REQ_W'(base) * REQ_W'(ticks_per_us);
	assign elapsed  = counter - stamp;
	assign reached  = REQ_W'(elapsed) >= required;

	always_comb begin
		dec = '0;
		case (action)
			ACT_TICK: begin
				dec.tick = 1'b1;
			end
			ACT_START: begin
				dec.bad_id    = !in_range;
				dec.stamp_we  = in_range;
				dec.set_valid = in_range;
			end
			ACT_CHECK: begin
				if (!in_range) begin
					dec.bad_id = 1'b1;
				end else if (!timer_valid) begin
					// Unstarted timer: arm it and report expired.
					dec.stamp_we  = 1'b1;
					dec.set_valid = 1'b1;
					dec.expired   = 1'b1;
				end else if (reached) begin
					dec.stamp_we = 1'b1;
					dec.expired  = 1'b1;
				end
			end
			default: begin
				dec = '0;
			end
		endcase
	end

endmodule

// ===== tb/periodic_soft_timer_bank_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_soft_timer_bank_core_tb
// Self-checking bench for the periodic soft timer bank core.
// ----------------------------------------------------------------------------
// Requests (tick, timer start, timer check, and the unused action code) are
// sent over the valid/ready input channel. Every accepted request beat is run
// through a behavioral copy of the timer bank: tick counter, start stamps,
// valid flags and the ticks-per-microsecond rate. The predicted result is
// queued, and every result beat taken from the output channel is compared,
// field by field, with the oldest queued prediction. A short directed run hits
// the field extremes and the special cases. Random phases at several rates
// follow, most of them with random idling on both channels.
// ----------------------------------------------------------------------------
module periodic_soft_timer_bank_core_tb;
	import pstb_pkg::*;

	localparam int NUM_TIMERS = 16;
	// The fourth action code has no name in the package; the core ignores it.
	localparam action_t ACT_UNUSED = 2'd3;
	// Fraction of cycles, in percent, that each side idles.
	localparam int IDLE_PCT = 12;

	// Behavioral copy of the timer bank plus the queue of awaited results.
	class timer_bank_scoreboard;
		logic [31:0]      tick_count;
		logic [31:0]      stamp [NUM_TIMERS];
		logic             armed [NUM_TIMERS];
		logic [TPU_W-1:0] rate;
		out_item_t        awaited [$];
		int unsigned      faults;

		function new();
			tick_count = '0;
			foreach (stamp[i]) begin
				stamp[i] = '0;
				armed[i] = 1'b0;
			end
			rate = TPU_RESET;
			faults = 0;
		endfunction

		// Apply one accepted request to the bank and queue the result it causes.
		function void note_request(in_item_t req);
			out_item_t   res;
			logic        in_bank;
			logic [31:0] elapsed;
			logic [63:0] ms_wide;
			logic [63:0] us_wide;
			logic [63:0] rate_wide;
			logic [63:0] deadline;
			res = '0;
			in_bank = req.timer_id < NUM_TIMERS;
			case (req.action)
				ACT_TICK: begin
					tick_count = tick_count + 32'd1;
				end
				ACT_START: begin
					if (in_bank) begin
						stamp[req.timer_id] = tick_count;
						armed[req.timer_id] = 1'b1;
					end else begin
						res.id_out_of_range = 1'b1;
					end
				end
				ACT_CHECK: begin
					if (!in_bank) begin
						res.id_out_of_range = 1'b1;
					end else if (!armed[req.timer_id]) begin
						stamp[req.timer_id] = tick_count;
						armed[req.timer_id] = 1'b1;
						res.expired = 1'b1;
					end else begin
						elapsed = tick_count - stamp[req.timer_id];
						ms_wide = 64'(req.interval_ms);
						us_wide = 64'(req.interval_us);
						rate_wide = 64'(rate);
						deadline = (ms_wide * 64'(US_PER_MS) + us_wide) * rate_wide;
						if ({32'd0, elapsed} >= deadline) begin
							stamp[req.timer_id] = tick_count;
							res.expired = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
			awaited.push_back(res);
		endfunction

		// Compare one result beat with the oldest awaited result.
		function void check_outcome(out_item_t got);
			out_item_t want;
			if (awaited.size() == 0) begin
				$error("result beat with nothing awaited: expired=%0b id_out_of_range=%0b",
					got.expired, got.id_out_of_range);
				faults++;
				return;
			end
			want = awaited.pop_front();
			if (got.expired !== want.expired) begin
				$error("expired: expected %0b, got %0b", want.expired, got.expired);
				faults++;
			end
			if (got.id_out_of_range !== want.id_out_of_range) begin
				$error("id_out_of_range: expected %0b, got %0b",
					want.id_out_of_range, got.id_out_of_range);
				faults++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_item_t         in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_item_t        out_data;
	logic             cfg_we = 1'b0;
	logic [TPU_W-1:0] cfg_wdata = '0;

	// While set, neither side idles.
	bit calm = 1'b0;

	timer_bank_scoreboard sb;

	periodic_soft_timer_bank_core #(
		.NUM_TIMERS(NUM_TIMERS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// Take result beats and pick the next ready level. Both valid and ready are
	// read here before this edge's updates land, so the handshake seen is the
	// one the core saw.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_outcome(out_data);
		end
		out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	function automatic in_item_t pack_request(action_t act, logic [7:0] id,
		logic [15:0] ms, logic [15:0] us);
		in_item_t req;
		req.action = act;
		req.timer_id = id;
		req.interval_ms = ms;
		req.interval_us = us;
		return req;
	endfunction

	// Draw one random request. Keep most ids on a few timers and most intervals
	// short, so that checks actually reach their deadlines; the rest span the
	// full field ranges.
	function automatic in_item_t random_request();
		in_item_t    req;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45) begin
			req.action = ACT_TICK;
		end else if (pick < 62) begin
			req.action = ACT_START;
		end else if (pick < 96) begin
			req.action = ACT_CHECK;
		end else begin
			req.action = ACT_UNUSED;
		end
		pick = $urandom_range(99);
		if (pick < 70) begin
			req.timer_id = 8'($urandom_range(3));
		end else if (pick < 90) begin
			req.timer_id = 8'($urandom_range(NUM_TIMERS - 1));
		end else begin
			req.timer_id = 8'($urandom_range(255));
		end
		if ($urandom_range(99) < 20) begin
			req.interval_ms = 16'($urandom_range(65535));
			req.interval_us = 16'($urandom_range(65535));
		end else begin
			req.interval_ms = ($urandom_range(99) < 5) ? 16'd1 : 16'd0;
			req.interval_us = 16'($urandom_range(40));
		end
		return req;
	endfunction

	// Send one request beat. Call right after a rising edge. Drop valid for a
	// short random gap now and then; otherwise hold it high straight into
	// the next beat.
	task automatic push_request(input in_item_t req);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		sb.note_request(req);
	endtask

	// Drop valid and wait until every awaited result has come (or a spin limit
	// runs out), then let the core settle.
	task automatic drain_results();
		int unsigned spins;
		spins = 0;
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0 && spins < 20000) begin
			@(posedge clk);
			spins++;
		end
		repeat (4) @(posedge clk);
	endtask

	// Change the rate only while the core is idle.
	task automatic write_rate(input logic [TPU_W-1:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.rate = value;
	endtask

	initial begin
		logic [TPU_W-1:0] phase_rate [6];
		sb = new();

		// Hold reset, then release it on an edge.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed run at the reset rate of 75.
		// First check of an unstarted timer arms it and reports expired.
		push_request(pack_request(ACT_CHECK, 8'd0, 16'd0, 16'd0));
		// Zero interval: the deadline is met at once.
		push_request(pack_request(ACT_CHECK, 8'd0, 16'd0, 16'd0));
		// One microsecond is 75 ticks away: not yet.
		push_request(pack_request(ACT_CHECK, 8'd0, 16'd0, 16'd1));
		// Ids past the bank: start is ignored, check changes nothing.
		push_request(pack_request(ACT_START, 8'd255, 16'hFFFF, 16'hFFFF));
		push_request(pack_request(ACT_CHECK, 8'd16, 16'd0, 16'd0));
		push_request(pack_request(ACT_CHECK, 8'd255, 16'hFFFF, 16'hFFFF));
		// Last timer of the bank; tick and unused code carry junk fields.
		push_request(pack_request(ACT_START, 8'd15, 16'hFFFF, 16'hFFFF));
		push_request(pack_request(ACT_TICK, 8'd255, 16'hFFFF, 16'hFFFF));
		push_request(pack_request(ACT_UNUSED, 8'd255, 16'hFFFF, 16'hFFFF));
		// Longest interval at this rate is far away; zero interval is not.
		push_request(pack_request(ACT_CHECK, 8'd15, 16'hFFFF, 16'hFFFF));
		push_request(pack_request(ACT_CHECK, 8'd15, 16'd0, 16'd0));

		// One tick per microsecond: walk a timer up to its deadline and past
		// the reload.
		write_rate(8'd1);
		push_request(pack_request(ACT_START, 8'd3, 16'd0, 16'd0));
		repeat (3) push_request(pack_request(ACT_TICK, 8'd0, 16'd0, 16'd0));
		push_request(pack_request(ACT_CHECK, 8'd3, 16'd0, 16'd4));
		push_request(pack_request(ACT_CHECK, 8'd3, 16'd0, 16'd3));
		push_request(pack_request(ACT_CHECK, 8'd3, 16'd0, 16'd1));

		// Zero rate: any check of an armed timer expires.
		write_rate(8'd0);
		push_request(pack_request(ACT_CHECK, 8'd3, 16'hFFFF, 16'hFFFF));

		// Top rate.
		write_rate(8'd255);
		push_request(pack_request(ACT_TICK, 8'd0, 16'd0, 16'd0));
		push_request(pack_request(ACT_CHECK, 8'd3, 16'd0, 16'd0));

		// Random phases, one rate each; the third runs with no idling at all.
		phase_rate[0] = 8'd1;
		phase_rate[1] = 8'd2;
		phase_rate[2] = 8'd1;
		phase_rate[3] = 8'd0;
		phase_rate[4] = 8'($urandom_range(255, 1));
		phase_rate[5] = TPU_RESET;
		for (int p = 0; p < 6; p++) begin
			write_rate(phase_rate[p]);
			calm = (p == 2);
			repeat (67) push_request(random_request());
		end
		calm = 1'b0;

		drain_results();
		repeat (8) @(posedge clk);
		if (sb.awaited.size() != 0) begin
			$error("%0d results never arrived", sb.awaited.size());
			sb.faults++;
		end
		if (sb.faults == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
